[src/pws_pkg.sv]
// Shared types and constants for the perspective world-to-screen projector.
package pws_pkg;

  localparam logic OP_LOAD    = 1'b0;
  localparam logic OP_PROJECT = 1'b1;

  localparam logic [0:0] CFG_WIDTH  = 1'b0;
  localparam logic [0:0] CFG_HEIGHT = 1'b1;

  localparam int WIN_W  = 14;
  localparam int DATA_W = 32;
  // exact clip sums: three floored 63-bit products plus a 32-bit term, FRAC_BITS down to 8
  localparam int CLIP_W = 57;

  localparam logic signed [63:0] S32_MAX = 64'sd2147483647;
  localparam logic signed [63:0] S32_MIN = -64'sd2147483648;

  typedef struct packed {
    logic               vis;
    logic signed [31:0] nx;
    logic signed [31:0] ny;
  } ndc_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > S32_MAX) r = 32'sh7fffffff;
    else if (v < S32_MIN) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

endpackage

[src/pws_clip.sv]
// Matrix store and clip-space transform: products, floor, row sums.
module pws_clip import pws_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     adv,
  input  logic                     in_v,
  input  logic                     in_op,
  input  logic [3:0]               in_idx,
  input  logic signed [31:0]       in_coef,
  input  logic signed [31:0]       in_x,
  input  logic signed [31:0]       in_y,
  input  logic signed [31:0]       in_z,
  output logic                     clip_v,
  output logic signed [CLIP_W-1:0] clip_x,
  output logic signed [CLIP_W-1:0] clip_y,
  output logic signed [CLIP_W-1:0] clip_w
);

  logic signed [31:0] mat_r [16];
  logic               p1_v_r;
  logic signed [63:0] prod_r [9];
  logic signed [31:0] tr_r [3];
  logic               p2_v_r;
  logic signed [CLIP_W-1:0] sum_r [3];
  logic signed [31:0] pt [3];
  localparam int ROW [3] = '{0, 1, 3};

  assign pt[0] = in_x;
  assign pt[1] = in_y;
  assign pt[2] = in_z;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 16; i++) mat_r[i] <= '0;
    end else if (adv && in_v && in_op == OP_LOAD) begin
      mat_r[in_idx] <= in_coef;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_v_r <= 1'b0;
      p2_v_r <= 1'b0;
    end else if (adv) begin
      p1_v_r <= in_v && in_op == OP_PROJECT;
      p2_v_r <= p1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) prod_r[r*3+c] <= pt[c] * mat_r[c*4+ROW[r]];
        tr_r[r] <= mat_r[12+ROW[r]];
      end
      for (int r = 0; r < 3; r++) begin
        sum_r[r] <= CLIP_W'(prod_r[r*3] >>> FRAC_BITS)
                  + CLIP_W'(prod_r[r*3+1] >>> FRAC_BITS)
                  + CLIP_W'(prod_r[r*3+2] >>> FRAC_BITS)
                  + CLIP_W'(tr_r[r]);
      end
    end
  end

  assign clip_v = p2_v_r;
  assign clip_x = sum_r[0];
  assign clip_y = sum_r[1];
  assign clip_w = sum_r[2];

endmodule

[src/pws_div.sv]
// Pipelined restoring divider producing saturated NDC x and y.
module pws_div import pws_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     adv,
  input  logic                     clip_v,
  input  logic signed [CLIP_W-1:0] clip_x,
  input  logic signed [CLIP_W-1:0] clip_y,
  input  logic signed [CLIP_W-1:0] clip_w,
  output logic                     ndc_v,
  output ndc_t                     ndc
);

  localparam int QB    = CLIP_W + FRAC_BITS;
  localparam int STEPS = QB;
  localparam int PER   = 4;
  localparam int NST   = (STEPS + PER - 1) / PER;
  localparam logic [CLIP_W-1:0] W_MIN = CLIP_W'(((64'd1 << FRAC_BITS) + 64'd9) / 64'd10);
  localparam int RW    = CLIP_W + 1;

  typedef struct packed {
    logic              v;
    logic              vis;
    logic              negx;
    logic              negy;
    logic [CLIP_W-1:0] d;
    logic [QB-1:0]     nx;
    logic [QB-1:0]     ny;
    logic [RW-1:0]     rx;
    logic [RW-1:0]     ry;
  } dst_t;

  dst_t st_r [NST+1];
  dst_t st0;

  always_comb begin
    st0.v    = clip_v;
    st0.vis  = $signed(clip_w) >= $signed({1'b0, W_MIN[CLIP_W-2:0]});
    st0.negx = clip_x[CLIP_W-1];
    st0.negy = clip_y[CLIP_W-1];
    st0.d    = clip_w;
    st0.nx   = {(st0.negx ? -clip_x : clip_x), {FRAC_BITS{1'b0}}};
    st0.ny   = {(st0.negy ? -clip_y : clip_y), {FRAC_BITS{1'b0}}};
    st0.rx   = '0;
    st0.ry   = '0;
  end

  for (genvar g = 0; g < NST; g++) begin : g_st
    dst_t src, dst;
    assign src = (g == 0) ? st0 : st_r[g];
    always_comb begin
      logic [RW-1:0] t;
      dst = src;
      for (int k = 0; k < PER; k++) begin
        if (g*PER + k < STEPS) begin
          t = {dst.rx[RW-2:0], dst.nx[QB-1]};
          dst.nx = {dst.nx[QB-2:0], 1'b0};
          if (t >= {1'b0, dst.d}) begin t = t - {1'b0, dst.d}; dst.nx[0] = 1'b1; end
          dst.rx = t;
          t = {dst.ry[RW-2:0], dst.ny[QB-1]};
          dst.ny = {dst.ny[QB-2:0], 1'b0};
          if (t >= {1'b0, dst.d}) begin t = t - {1'b0, dst.d}; dst.ny[0] = 1'b1; end
          dst.ry = t;
        end
      end
    end
    always_ff @(posedge clk) begin
      if (!rst_n) st_r[g+1].v <= 1'b0;
      else if (adv) st_r[g+1] <= dst;
    end
  end

  assign st_r[0] = st0;

  function automatic logic signed [31:0] fin(input logic [QB-1:0] q, input logic neg);
    logic signed [63:0] s;
    s = $signed(64'(q));
    if (q[QB-1:32] != '0) s = 64'sh7fffffffffffffff;
    return sat32(neg ? -s : s);
  endfunction

  assign ndc_v   = st_r[NST].v;
  assign ndc.vis = st_r[NST].vis;
  assign ndc.nx  = st_r[NST].vis ? fin(st_r[NST].nx, st_r[NST].negx) : '0;
  assign ndc.ny  = st_r[NST].vis ? fin(st_r[NST].ny, st_r[NST].negy) : '0;

endmodule

[src/perspective_world_to_screen.sv]
// Top level: world point to screen projector with matrix load and viewport map.
//  channel | dir | beat
//  in_     | in  | tuser=operation, tdata={pos_z,pos_y,pos_x,coef_value,coef_index}
//  out_    | out | tuser=visible, tdata={screen_y,screen_x}
//  cfg_    | in  | index 0 width, 1 height
// One item per cycle unless the output stalls; 2 clip, 19 divider, 2 map stages.
// The divider pipeline (73 quotient bits, 4 per stage) sets the depth.
// Reset clears the matrix, valid bits and sets the viewport to 1920x1080.
// A stalled output freezes the whole pipeline; no beat is lost or repeated.
module perspective_world_to_screen import pws_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [167:0] in_tdata,  // coef_index, coef_value, pos_x, pos_y, pos_z
  input  logic         in_tuser,  // operation
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [63:0]  out_tdata, // screen_x, screen_y
  output logic         out_tuser, // visible
  input  logic         cfg_we,
  input  logic [0:0]   cfg_index,
  input  logic [13:0]  cfg_wdata
);

  logic adv;
  logic [WIN_W-1:0] win_w_r, win_h_r;
  logic clip_v, ndc_v;
  logic signed [CLIP_W-1:0] cx, cy, cw;
  ndc_t ndc;
  logic m_v_r, o_v_r;
  logic m_vis_r, o_vis_r;
  logic signed [63:0] px_r, py_r, nx_r, ny_r, hx_r, hy_r;
  logic signed [31:0] sx_r, sy_r;

  assign adv = !o_v_r || out_tready;
  assign in_tready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_w_r <= WIN_W'(1920);
      win_h_r <= WIN_W'(1080);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_WIDTH:  win_w_r <= cfg_wdata;
        CFG_HEIGHT: win_h_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  pws_clip #(.FRAC_BITS(FRAC_BITS)) u_clip (
    .clk, .rst_n, .adv,
    .in_v(in_tvalid), .in_op(in_tuser), .in_idx(in_tdata[3:0]),
    .in_coef(in_tdata[35:4]), .in_x(in_tdata[67:36]), .in_y(in_tdata[99:68]),
    .in_z(in_tdata[131:100]),
    .clip_v, .clip_x(cx), .clip_y(cy), .clip_w(cw)
  );

  pws_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk, .rst_n, .adv, .clip_v, .clip_x(cx), .clip_y(cy), .clip_w(cw),
    .ndc_v, .ndc
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_v_r <= 1'b0;
      o_v_r <= 1'b0;
    end else if (adv) begin
      m_v_r <= ndc_v;
      o_v_r <= m_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m_vis_r <= ndc.vis;
      px_r <= 64'(win_w_r[WIN_W-1:1]) * 64'(ndc.nx);
      py_r <= 64'(win_h_r[WIN_W-1:1]) * 64'(ndc.ny);
      nx_r <= 64'(ndc.nx);
      ny_r <= 64'(ndc.ny);
      hx_r <= 64'(win_w_r[WIN_W-1:1]) <<< FRAC_BITS;
      hy_r <= 64'(win_h_r[WIN_W-1:1]) <<< FRAC_BITS;
      o_vis_r <= m_vis_r;
      sx_r <= m_vis_r ? sat32(px_r + nx_r + hx_r) : '0;
      sy_r <= m_vis_r ? sat32(-py_r + ny_r + hy_r) : '0;
    end
  end

  assign out_tvalid = o_v_r;
  assign out_tuser  = o_vis_r;
  assign out_tdata  = {sy_r, sx_r};

  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata == '0) else $error("hidden point nonzero");
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid) else $error("result dropped");
  assert property (@(posedge clk) disable iff (!rst_n)
    in_tready == (!out_tvalid || out_tready)) else $error("ready mismatch");

endmodule
